/* design/xhlp_pkg.sv */
// ----------------------------------------------------------------------------
// xhlp_pkg
// Shared types and constants of the horizontal leash projection block.
// ----------------------------------------------------------------------------
package xhlp_pkg;

  localparam int DIV_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_RIGHT = 2'd2;

  localparam logic [30:0] U31_MAX = 31'h7fff_ffff;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_CHECK,
    OP_ALPHA_SPECIAL,
    OP_ALPHA_START,
    OP_ALPHA_TAKE,
    OP_MUL_AL,
    OP_NUM_START,
    OP_Q_TAKE,
    OP_MUL_D,
    OP_COMMIT,
    OP_CLEAR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   arm;    // 0 left arm, 1 right arm
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic c_pos;
    logic dt2_zero;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [31:0] mark_min_x;
    logic signed [31:0] mark_max_x;
    logic signed [31:0] base_min_x;
    logic signed [31:0] base_max_x;
    logic [30:0]        mobility;
    logic [30:0]        time_step;
    logic               has_base;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] shift;
    logic               left_applied;
    logic               right_applied;
    logic signed [31:0] left_multiplier;
    logic signed [31:0] right_multiplier;
  } out_item_t;

endpackage

/* design/xhlp_div.sv */
// ----------------------------------------------------------------------------
// xhlp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xhlp_div
  import xhlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_W) + 1;

  logic [DIV_W:0]   rem_r, rem_nxt, rem_sh;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  always_comb begin
    rem_sh = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt = rem_sh - {1'b0, den_r};
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        den_r  <= divisor;
        cnt_r  <= CNT_W'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* design/xhlp_dp.sv */
// ----------------------------------------------------------------------------
// xhlp_dp
// Datapath: config registers, multipliers, shared divider, multiplier state.
// ----------------------------------------------------------------------------
module xhlp_dp
  import xhlp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg_wr,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  localparam int DT2_W = 62 - FRAC_BITS;

  logic [30:0] margin_r, comp_l_r, comp_r_r;

  logic signed [31:0] mmin_r, mmax_r, bmin_r, bmax_r;
  logic [30:0]        w_r, dt_r;
  logic               has_base_r;

  logic [DT2_W-1:0]   dt2_r;
  logic signed [33:0] xl_r, xr_r;
  logic signed [63:0] shift_r, c_r, al_r, d_r;
  logic [30:0]        alpha_r;
  logic               neg_r;
  logic signed [31:0] nl_r;
  logic signed [31:0] lam_l_r, lam_r_r;
  logic               lapp_r, rapp_r;
  out_item_t          out_r;

  logic [61:0]        dt_prod;
  logic signed [31:0] lam_sel;
  logic [30:0]        comp_sel;
  logic [63:0]        c_nxt;
  logic signed [63:0] al_prod, num, scaled;
  logic [63:0]        scaled_mag, denom;
  logic [DIV_W-1:0]   div_a, div_b, quo;
  logic               div_start, div_done;
  logic signed [31:0] q_s;
  logic signed [32:0] nl33, diff33;
  logic signed [64:0] d_prod, d_shift;
  logic signed [31:0] shift_sat;

  assign lam_sel  = cmd.arm ? lam_r_r : lam_l_r;
  assign comp_sel = cmd.arm ? comp_r_r : comp_l_r;
  assign dt_prod  = 62'(dt_r) * 62'(dt_r);

  always_comb begin
    if (cmd.arm) begin
      c_nxt = {{32{mmax_r[31]}}, mmax_r} + shift_r - {{30{xr_r[33]}}, xr_r};
    end else begin
      c_nxt = {{30{xl_r[33]}}, xl_r} - {{32{mmin_r[31]}}, mmin_r};
    end
  end

  assign al_prod    = $signed({1'b0, alpha_r}) * lam_sel;
  assign num        = c_r + al_r;
  assign scaled     = num <<< FRAC_BITS;
  assign scaled_mag = scaled[63] ? 64'(-scaled) : 64'(scaled);
  assign denom      = 64'(w_r) + 64'(alpha_r);

  // divider operands: alpha division or increment division
  always_comb begin
    if (cmd.op == OP_ALPHA_START) begin
      div_a = 64'(comp_sel) << FRAC_BITS;
      div_b = 64'(dt2_r);
    end else begin
      div_a = scaled_mag;
      div_b = denom;
    end
  end
  assign div_start = (cmd.op == OP_ALPHA_START) || (cmd.op == OP_NUM_START);

  xhlp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quo),
    .done     (div_done)
  );

  // saturated signed increment from magnitude and sign
  always_comb begin
    if (!neg_r) begin
      q_s = (quo > 64'(S32_MAX)) ? S32_MAX : $signed(quo[31:0]);
    end else begin
      q_s = (quo > 64'h8000_0000) ? S32_MIN : $signed(32'(-quo[31:0]));
    end
  end

  assign nl33    = $signed({lam_sel[31], lam_sel}) + $signed({q_s[31], q_s});
  assign diff33  = $signed({nl_r[31], nl_r}) - $signed({lam_sel[31], lam_sel});
  assign d_prod  = $signed({1'b0, w_r}) * diff33;
  assign d_shift = d_prod >>> FRAC_BITS;

  always_comb begin
    if (shift_r[63:31] == {33{1'b0}} || shift_r[63:31] == {33{1'b1}}) begin
      shift_sat = shift_r[31:0];
    end else begin
      shift_sat = shift_r[63] ? S32_MIN : S32_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
      comp_l_r <= '0;
      comp_r_r <= '0;
      lam_l_r  <= '0;
      lam_r_r  <= '0;
    end else begin
      if (cfg_wr.en) begin
        case (cfg_wr.idx)
          REG_MARGIN:     margin_r <= cfg_wr.data[30:0];
          REG_COMP_LEFT:  comp_l_r <= cfg_wr.data[30:0];
          REG_COMP_RIGHT: comp_r_r <= cfg_wr.data[30:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_COMMIT: begin
          if (cmd.arm) lam_r_r <= nl_r;
          else         lam_l_r <= nl_r;
        end
        OP_CLEAR: begin
          if (cmd.arm) lam_r_r <= '0;
          else         lam_l_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mmin_r     <= in_item.mark_min_x;
        mmax_r     <= in_item.mark_max_x;
        bmin_r     <= in_item.base_min_x;
        bmax_r     <= in_item.base_max_x;
        w_r        <= in_item.mobility;
        dt_r       <= in_item.time_step;
        has_base_r <= in_item.has_base;
        shift_r    <= '0;
        lapp_r     <= 1'b0;
        rapp_r     <= 1'b0;
      end
      OP_PREP: begin
        dt2_r <= dt_prod[61:FRAC_BITS];
        xl_r  <= {{2{bmin_r[31]}}, bmin_r} - {3'b000, margin_r};
        xr_r  <= {{2{bmax_r[31]}}, bmax_r} + {3'b000, margin_r};
      end
      OP_CHECK:         c_r     <= c_nxt;
      OP_ALPHA_SPECIAL: alpha_r <= (comp_sel != '0) ? U31_MAX : '0;
      OP_ALPHA_TAKE:    alpha_r <= (quo[63:31] != '0) ? U31_MAX : quo[30:0];
      OP_MUL_AL:        al_r    <= al_prod >>> FRAC_BITS;
      OP_NUM_START:     neg_r   <= !scaled[63] && (scaled != '0);
      OP_Q_TAKE: begin
        if (!nl33[32] && nl33 != '0) begin
          nl_r <= '0;
        end else if (nl33[32] && !nl33[31]) begin
          nl_r <= S32_MIN;
        end else begin
          nl_r <= nl33[31:0];
        end
      end
      OP_MUL_D: d_r <= d_shift[63:0];
      OP_COMMIT: begin
        if (cmd.arm) begin
          shift_r <= shift_r + d_r;
          rapp_r  <= 1'b1;
        end else begin
          shift_r <= shift_r - d_r;
          lapp_r  <= 1'b1;
        end
      end
      OP_OUT: begin
        out_r.shift            <= shift_sat;
        out_r.left_applied     <= lapp_r;
        out_r.right_applied    <= rapp_r;
        out_r.left_multiplier  <= lam_l_r;
        out_r.right_multiplier <= lam_r_r;
      end
      default: ;
    endcase
  end

  assign stat.skip     = (w_r == '0) || !has_base_r;
  assign stat.c_pos    = !c_r[63] && (c_r != '0);
  assign stat.dt2_zero = (dt2_r == '0);
  assign stat.div_done = div_done;
  assign out_item      = out_r;

endmodule

/* design/xhlp_ctrl.sv */
// ----------------------------------------------------------------------------
// xhlp_ctrl
// Controller: sequences one projection step over the datapath.
// ----------------------------------------------------------------------------
module xhlp_ctrl
  import xhlp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_PREP, S_CHECK, S_BRANCH, S_ALPHA_WAIT, S_MUL_AL,
    S_NUM, S_DIV_WAIT, S_MUL_D, S_COMMIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   arm_r, arm_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    arm_nxt       = arm_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.arm       = arm_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: state_nxt = stat.skip ? S_OUT : S_PREP;
      S_PREP: begin
        cmd.op    = OP_PREP;
        arm_nxt   = 1'b0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        if (!stat.c_pos) begin
          cmd.op    = OP_CLEAR;
          arm_nxt   = 1'b1;
          state_nxt = arm_r ? S_OUT : S_CHECK;
        end else if (stat.dt2_zero) begin
          cmd.op    = OP_ALPHA_SPECIAL;
          state_nxt = S_MUL_AL;
        end else begin
          cmd.op    = OP_ALPHA_START;
          state_nxt = S_ALPHA_WAIT;
        end
      end
      S_ALPHA_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_ALPHA_TAKE;
          state_nxt = S_MUL_AL;
        end
      end
      S_MUL_AL: begin
        cmd.op    = OP_MUL_AL;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = OP_NUM_START;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_Q_TAKE;
          state_nxt = S_MUL_D;
        end
      end
      S_MUL_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        arm_nxt   = 1'b1;
        state_nxt = arm_r ? S_OUT : S_CHECK;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arm_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arm_r       <= arm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* design/xpbd_horizontal_leash_projection_top.sv */
// ----------------------------------------------------------------------------
// xpbd_horizontal_leash_projection_top
// One XPBD inequality projection step keeping a mark inside its base extent.
// ----------------------------------------------------------------------------
// One word in gives one word out. Items are handled one at a time: a fixed
// mark or one without a base skips both arms, and every breached arm uses
// the shared 64-step radix-2 divider twice (alpha, then the multiplier
// increment); when dt^2 rounds to zero the alpha division is skipped.
// The result sits in an output register, so the next word is taken while it
// waits. Left and right multipliers persist across words, are cleared for an
// arm that is not breached, and reset to zero.
// Config writes (margin, left and right compliance) are always ready and
// should be issued only while the block is idle.
// ----------------------------------------------------------------------------
module xpbd_horizontal_leash_projection_top
  import xhlp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // input word
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_mark_min_x,
  input  logic signed [31:0]   in_mark_max_x,
  input  logic signed [31:0]   in_base_min_x,
  input  logic signed [31:0]   in_base_max_x,
  input  logic [30:0]          in_mobility,
  input  logic [30:0]          in_time_step,
  input  logic                 in_has_base,
  // result word
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_shift,
  output logic                 out_left_applied,
  output logic                 out_right_applied,
  output logic signed [31:0]   out_left_multiplier,
  output logic signed [31:0]   out_right_multiplier
);

  cfg_wr_t   cfg_wr;
  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  assign cfg_ready   = 1'b1;
  assign cfg_wr.en   = cfg_valid;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_data;

  assign in_item.mark_min_x = in_mark_min_x;
  assign in_item.mark_max_x = in_mark_max_x;
  assign in_item.base_min_x = in_base_min_x;
  assign in_item.base_max_x = in_base_max_x;
  assign in_item.mobility   = in_mobility;
  assign in_item.time_step  = in_time_step;
  assign in_item.has_base   = in_has_base;

  xhlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  xhlp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  assign out_shift            = out_item.shift;
  assign out_left_applied     = out_item.left_applied;
  assign out_right_applied    = out_item.right_applied;
  assign out_left_multiplier  = out_item.left_multiplier;
  assign out_right_multiplier = out_item.right_multiplier;

endmodule

/* tb/tb_xpbd_horizontal_leash_projection_top.sv */
// ----------------------------------------------------------------------------
// tb_xpbd_horizontal_leash_projection_top
// Self-checking bench for the horizontal leash projection step: a predictor
// class mirrors the multipliers and config, random bursts and stalls on both
// words channels, config changes between idle phases.
// ----------------------------------------------------------------------------
module tb_xpbd_horizontal_leash_projection_top;
  import xhlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC       = 16;
  localparam int  DRAIN_WAIT = 400;   // wait after the last result, above the worst step
  localparam int  STALL_LIMIT = 6000; // cycles with no handshake at all
  localparam longint S32_HI  = 64'sd2147483647;
  localparam longint S32_LO  = -64'sd2147483648;

  // --------------------------------------------------------------------------
  // Predictor and result check
  // --------------------------------------------------------------------------
  class leash_checker;
    longint    margin_q, comp_left_q, comp_right_q;
    longint    lam_left, lam_right;
    out_item_t expected_steps[$];
    int        errors;

    function new();
      margin_q = 0; comp_left_q = 0; comp_right_q = 0;
      lam_left = 0; lam_right = 0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_MARGIN:     margin_q     = longint'(data[30:0]);
        REG_COMP_LEFT:  comp_left_q  = longint'(data[30:0]);
        REG_COMP_RIGHT: comp_right_q = longint'(data[30:0]);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
    endfunction

    // alpha = compliance / dt^2, saturated; dt^2 of zero pins it high, or to zero for zero compliance
    function longint alpha_of(longint comp, longint unsigned dt2);
      longint unsigned a;
      if (dt2 == 0) return (comp != 0) ? S32_HI : 0;
      a = (longint'(comp) << FRAC) / dt2;
      if (a > longint'(S32_HI)) return S32_HI;
      return longint'(a);
    endfunction

    // one inequality arm: new multiplier back, mobility-weighted move in d
    function longint project_arm(longint c, longint alpha, longint w, longint lam,
                                 output longint d);
      longint den, num, q, nl;
      den = w + alpha;
      num = c + ((alpha * lam) >>> FRAC);
      q   = clamp32((-(num * 65536)) / den);
      nl  = lam + q;
      if (nl > 0) nl = 0;
      if (nl < S32_LO) nl = S32_LO;
      d = (w * (nl - lam)) >>> FRAC;
      return nl;
    endfunction

    function void note_step(in_item_t it);
      longint          mmin, mmax, bmin, bmax, w, xl, xr, c, d, shift;
      longint unsigned dt, dt2;
      out_item_t       r;
      mmin = longint'($signed(it.mark_min_x));
      mmax = longint'($signed(it.mark_max_x));
      bmin = longint'($signed(it.base_min_x));
      bmax = longint'($signed(it.base_max_x));
      w    = longint'(it.mobility);
      dt   = longint'(it.time_step);
      shift = 0;
      r = '0;
      if (w != 0 && it.has_base) begin
        dt2 = (dt * dt) >> FRAC;
        xl  = bmin - margin_q;
        xr  = bmax + margin_q;
        c = xl - mmin;
        if (c > 0) begin
          lam_left = project_arm(c, alpha_of(comp_left_q, dt2), w, lam_left, d);
          shift = shift - d;
          r.left_applied = 1'b1;
        end else begin
          lam_left = 0;
        end
        // right arm sees the box already moved by the left arm
        c = (mmax + shift) - xr;
        if (c > 0) begin
          lam_right = project_arm(c, alpha_of(comp_right_q, dt2), w, lam_right, d);
          shift = shift + d;
          r.right_applied = 1'b1;
        end else begin
          lam_right = 0;
        end
      end
      r.shift            = clamp32(shift);
      r.left_multiplier  = lam_left;
      r.right_multiplier = lam_right;
      expected_steps = {expected_steps, r};
    endfunction

    function void check_result(out_item_t act);
      out_item_t e;
      if (expected_steps.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = expected_steps.pop_front();
      if (act.shift !== e.shift) begin
        $error("shift exp %0d got %0d", e.shift, act.shift);
        errors++;
      end
      if (act.left_applied !== e.left_applied) begin
        $error("left_applied exp %0b got %0b", e.left_applied, act.left_applied);
        errors++;
      end
      if (act.right_applied !== e.right_applied) begin
        $error("right_applied exp %0b got %0b", e.right_applied, act.right_applied);
        errors++;
      end
      if (act.left_multiplier !== e.left_multiplier) begin
        $error("left_multiplier exp %0d got %0d", e.left_multiplier, act.left_multiplier);
        errors++;
      end
      if (act.right_multiplier !== e.right_multiplier) begin
        $error("right_multiplier exp %0d got %0d", e.right_multiplier,
               act.right_multiplier);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                 clk, rst_n;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid, in_stall;
  logic signed [31:0]   in_mark_min_x, in_mark_max_x, in_base_min_x, in_base_max_x;
  logic [30:0]          in_mobility, in_time_step;
  logic                 in_has_base;
  logic                 out_valid, out_stall;
  logic signed [31:0]   out_shift;
  logic                 out_left_applied, out_right_applied;
  logic signed [31:0]   out_left_multiplier, out_right_multiplier;

  xpbd_horizontal_leash_projection_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mark_min_x       (in_mark_min_x),
    .in_mark_max_x       (in_mark_max_x),
    .in_base_min_x       (in_base_min_x),
    .in_base_max_x       (in_base_max_x),
    .in_mobility         (in_mobility),
    .in_time_step        (in_time_step),
    .in_has_base         (in_has_base),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_shift           (out_shift),
    .out_left_applied    (out_left_applied),
    .out_right_applied   (out_right_applied),
    .out_left_multiplier (out_left_multiplier),
    .out_right_multiplier(out_right_multiplier)
  );

  leash_checker chk = new();
  int           idle_cycles;
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // all inputs known from time zero
  initial begin
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_mark_min_x <= '0;
    in_mark_max_x <= '0;
    in_base_min_x <= '0;
    in_base_max_x <= '0;
    in_mobility   <= '0;
    in_time_step  <= 31'd1;
    in_has_base   <= 1'b0;
    out_stall     <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitors: sample at the edge, so values are the pre-edge ones
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t  iw;
    out_item_t ow;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        iw.mark_min_x = in_mark_min_x;
        iw.mark_max_x = in_mark_max_x;
        iw.base_min_x = in_base_min_x;
        iw.base_max_x = in_base_max_x;
        iw.mobility   = in_mobility;
        iw.time_step  = in_time_step;
        iw.has_base   = in_has_base;
        chk.note_step(iw);
      end
      if (out_valid && !out_stall) begin
        ow.shift            = out_shift;
        ow.left_applied     = out_left_applied;
        ow.right_applied    = out_right_applied;
        ow.left_multiplier  = out_left_multiplier;
        ow.right_multiplier = out_right_multiplier;
        chk.check_result(ow);
      end
    end
  end

  // Receiver: runs of stall / no stall, now and then a long open stretch
  always @(posedge clk) begin
    int  run_left;
    bit  hold;
    if (run_left <= 0) begin
      if ($urandom_range(0, 7) == 0) begin
        hold = 1'b0;
        run_left = 200;
      end else begin
        hold = ($urandom_range(0, 2) == 0);
        run_left = hold ? $urandom_range(1, 15) : $urandom_range(1, 30);
      end
    end
    run_left--;
    out_stall <= hold;
  end

  // Watchdog: no handshake of any kind for too long means a hang
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // cfg_valid drops after each write, which keeps back to back writes apart
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    chk.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender works in bursts; between bursts valid stays low over a gap, so it is
  // never dropped and raised at the same edge
  task automatic send_word(in_item_t it);
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid      <= 1'b1;
    in_mark_min_x <= it.mark_min_x;
    in_mark_max_x <= it.mark_max_x;
    in_base_min_x <= it.base_min_x;
    in_base_max_x <= it.base_max_x;
    in_mobility   <= it.mobility;
    in_time_step  <= it.time_step;
    in_has_base   <= it.has_base;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // all results in, then let the engine settle before touching config
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (chk.expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic in_item_t mk(int mmin, int mmax, int bmin, int bmax,
                                  int w, int dt, bit hb);
    in_item_t it;
    it.mark_min_x = mmin;
    it.mark_max_x = mmax;
    it.base_min_x = bmin;
    it.base_max_x = bmax;
    it.mobility   = w[30:0];
    it.time_step  = dt[30:0];
    it.has_base   = hb;
    return it;
  endfunction

  function automatic int pick_mobility();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(1, 255);
      1:       return $urandom & 32'h7fff_ffff;
      2:       return 0;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(1, 255);        // dt^2 rounds to zero
      1:       return $urandom_range(1, 32'h7fff_ffff);
      default: return $urandom_range(32'h0000_0100, 32'h0004_0000);
    endcase
  endfunction

  // Mostly solver-like runs on one geometry so the multipliers carry over;
  // the rest is raw noise over the full field ranges.
  task automatic random_steps(int count);
    int       sent, run, bmin, bwid, mmin, mwid, w, dt;
    in_item_t it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        it = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 1));
        if (it.time_step == 0) it.time_step = 31'd1;
        send_word(it);
        sent++;
      end else begin
        bmin = int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
        bwid = $urandom_range(0, 32'h0020_0000);
        mmin = bmin + int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        mwid = $urandom_range(0, 32'h0024_0000);
        w    = pick_mobility();
        dt   = pick_step();
        run  = $urandom_range(1, 6);
        repeat (run) begin
          send_word(mk(mmin, mmin + mwid, bmin, bmin + bwid, w, dt,
                       $urandom_range(0, 19) != 0));
          sent++;
        end
      end
    end
  endtask

  // fixed mark, no base, each arm, both arms, edge values of every field
  task automatic directed_steps();
    send_word(mk(-100, 900000, 0, 65536, 0, 65536, 1));            // fixed mark
    send_word(mk(-100, 900000, 0, 65536, 65536, 65536, 0));        // no base
    send_word(mk(1000, 2000, 0, 65536, 65536, 65536, 1));          // inside
    send_word(mk(-300000, 2000, 0, 65536, 65536, 65536, 1));       // left only
    send_word(mk(-300000, 2000, 0, 65536, 65536, 65536, 1));       // left again
    send_word(mk(1000, 400000, 0, 65536, 65536, 65536, 1));        // right only
    send_word(mk(-300000, 400000, 0, 65536, 32768, 65536, 1));     // both arms
    send_word(mk(-300000, 400000, 0, 65536, 32768, 1, 1));         // tiny step
    send_word(mk(-300000, 400000, 0, 65536, 1, 32'h7fff_ffff, 1)); // least mobility
    send_word(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 1));
    send_word(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 1, 1));
    send_word(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 1, 32'h7fff_ffff, 1));
    send_word(mk(0, 0, 0, 0, 65536, 65536, 1));                    // clears both
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: zero margin and compliance
    random_steps(100);
    drain();

    // moderate config, then the directed cases
    cfg_write(REG_MARGIN, 32'h0000_1000);
    cfg_write(REG_COMP_LEFT, 32'h0000_0100);
    cfg_write(REG_COMP_RIGHT, 32'h0001_0000);
    directed_steps();
    random_steps(120);
    drain();

    // every register at its top value; bit 31 of the data is dropped
    cfg_write(REG_MARGIN, 32'hffff_ffff);
    cfg_write(REG_COMP_LEFT, 32'hffff_ffff);
    cfg_write(REG_COMP_RIGHT, 32'h7fff_ffff);
    directed_steps();
    random_steps(60);
    drain();

    // stiff arms, random margin
    cfg_write(REG_MARGIN, $urandom_range(0, 32'h0002_0000));
    cfg_write(REG_COMP_LEFT, 32'h0);
    cfg_write(REG_COMP_RIGHT, 32'h0);
    random_steps(120);
    drain();

    // random soft arms
    cfg_write(REG_MARGIN, $urandom_range(0, 32'h0001_0000));
    cfg_write(REG_COMP_LEFT, $urandom);
    cfg_write(REG_COMP_RIGHT, $urandom_range(0, 32'h0010_0000));
    random_steps(180);
    drain();

    if (chk.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
